### hdl/assert_macros.svh
// Assertion helpers for the block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Flag a condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### hdl/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_DESC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP  = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_PEEK   = 2'd1,
    REQ_POLL   = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cell update select, driven by the queue control.
  typedef struct packed {
    logic load;       // take the inserted value
    logic take_prev;  // shift toward the tail: take the neighbor at i-1
    logic take_next;  // shift toward the head: take the neighbor at i+1
  } cell_ctrl_t;

endpackage

### hdl/spq_cell.sv
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic signed [VAL_W-1:0] prev_val,
  input  logic signed [VAL_W-1:0] next_val,
  input  logic signed [VAL_W-1:0] ins_val,
  input  logic                    desc,
  output logic signed [VAL_W-1:0] value_o,
  output logic                    ahead_o
);

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;

  // New value belongs ahead of this entry under the current order.
  assign ahead_o = desc ? (value_r < ins_val) : (value_r > ins_val);
  assign value_o = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.load) begin
      value_nxt = ins_val;
    end else if (ctrl.take_prev) begin
      value_nxt = prev_val;
    end else if (ctrl.take_next) begin
      value_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

### hdl/sorted_priority_queue.sv
// Sorted priority queue of signed 32-bit values held in a row of cells.
// Input channel: in_valid / in_stall with in_req_type (insert, peek, poll)
// and in_value; a beat is taken when in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with out_head_value, out_status
// and out_occupancy, one result beat for every request beat.
// Configuration: cfg_we with cfg_index (0 order, 1 capacity) and
// cfg_wdata; write only while no request is in flight.
// The result is registered and shows in the cycle after the request is
// taken. One request per cycle while the result is not stalled; every cell
// compares against the new value and shifts by one slot in the same cycle,
// so the whole row updates together.
// A stalled result holds its register and in_stall rises until the result
// beat is taken; no request is taken meanwhile.
// Reset (rst_n low at a clock edge) empties the queue, selects ascending
// order and sets capacity to 16; stored values are not cleared.
`include "assert_macros.svh"

module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_req_type,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_head_value,
  output logic [1:0]              out_status,
  output logic [CNT_W-1:0]        out_occupancy,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic                    desc_r;
  logic [CAP_W-1:0]        cap_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [VAL_W-1:0] head_r;
  logic signed [VAL_W-1:0] head_nxt;
  status_t                 status_r;
  status_t                 status_nxt;

  logic                    accept;
  req_t                    req;
  logic [CNT_W-1:0]        limit;
  logic                    full;
  logic                    empty;
  logic                    do_insert;
  logic                    do_poll;

  logic signed [VAL_W-1:0] cell_val  [DEPTH];
  logic signed [VAL_W-1:0] prev_arr  [DEPTH];
  logic signed [VAL_W-1:0] next_arr  [DEPTH];
  cell_ctrl_t              cell_ctrl [DEPTH];
  logic [DEPTH-1:0]        ahead;
  logic [DEPTH-1:0]        occupied;
  logic [DEPTH-1:0]        stop;
  logic [DEPTH-1:0]        none_ge;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign req      = req_t'(in_req_type);

  assign limit = (CNT_W'(cap_r) < CNT_W'(DEPTH)) ? CNT_W'(cap_r) : CNT_W'(DEPTH);
  assign full  = count_r >= limit;
  assign empty = count_r == '0;

  assign do_insert = accept && (req == REQ_INSERT) && !full;
  assign do_poll   = accept && (req == REQ_POLL) && !empty;

  // An entry stops the insert scan when it is stored and the value does
  // not go ahead of it; the value lands just behind the highest stop.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      occupied[k] = CNT_W'(k) < count_r;
      stop[k]     = occupied[k] & ~ahead[k];
    end
    for (int k = 0; k < DEPTH; k++) begin
      none_ge[k] = ~|(stop & ({DEPTH{1'b1}} << k));
    end
  end

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      prev_arr[k]  = (k == 0) ? in_value : cell_val[(k == 0) ? 0 : k - 1];
      next_arr[k]  = (k == DEPTH - 1) ? cell_val[k] : cell_val[(k == DEPTH - 1) ? k : k + 1];
      cell_ctrl[k] = '0;
      if (do_insert && (CNT_W'(k) <= count_r)) begin
        if (k == 0) begin
          cell_ctrl[k].load = none_ge[0];
        end else if (none_ge[(k == 0) ? 0 : k - 1]) begin
          cell_ctrl[k].take_prev = 1'b1;
        end else begin
          cell_ctrl[k].load = stop[(k == 0) ? 0 : k - 1] & none_ge[k];
        end
      end else if (do_poll) begin
        cell_ctrl[k].take_next = 1'b1;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[i]),
      .prev_val (prev_arr[i]),
      .next_val (next_arr[i]),
      .ins_val  (in_value),
      .desc     (desc_r),
      .value_o  (cell_val[i]),
      .ahead_o  (ahead[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & out_stall;
    head_nxt      = head_r;
    status_nxt    = status_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      head_nxt      = '0;
      status_nxt    = ST_OK;
      case (req)
        REQ_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        REQ_PEEK, REQ_POLL: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt = cell_val[0];
            if (req == REQ_POLL) begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      desc_r      <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DESC: desc_r <= cfg_wdata[0];
          CFG_CAP:  cap_r  <= cfg_wdata[CAP_W-1:0];
          default:  cap_r  <= cap_r;
        endcase
      end
    end
  end

  // Result payload holds while the beat is stalled.
  always_ff @(posedge clk) begin
    head_r   <= head_nxt;
    status_r <= status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_head_value = head_r;
  assign out_status     = status_r;
  assign out_occupancy  = count_r;

  `ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > CNT_W'(DEPTH))
  `ASSERT_CLK(a_stall_needs_result, clk, rst_n, in_stall |-> out_valid_r)
  `ASSERT_CLK(a_empty_result, clk, rst_n,
    (out_valid_r && status_r == ST_EMPTY) |-> (count_r == '0 && head_r == '0))
  `ASSERT_CLK(a_poll_count, clk, rst_n,
    do_poll |=> (count_r == $past(count_r) - 1'b1))

endmodule
